// ===== src/amg_strong_connection_select_macros.svh =====
`ifndef AMG_STRONG_CONNECTION_SELECT_MACROS_SVH
`define AMG_STRONG_CONNECTION_SELECT_MACROS_SVH

// same-cycle implication
`define AMG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AMG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/amg_scs_pkg.sv =====
package amg_scs_pkg;

   localparam int COL_W      = 16;
   localparam int VAL_W      = 32;
   localparam int MAG_W      = 31;
   localparam int SUM_W      = 40;
   localparam int THETA_W    = 17;
   localparam int TAU_W      = 24;
   localparam int DEG_W      = 7;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   localparam logic [THETA_W-1:0] THETA_RESET = THETA_W'(16384);
   localparam logic [TAU_W-1:0]   TAU_RESET   = TAU_W'(65536);

   localparam logic [CSR_IDX_W-1:0] REG_THETA = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_TAU   = CSR_IDX_W'(1);

   typedef struct packed {
      logic acc;
      logic mul_lo;
      logic mul_hi;
      logic judge;
      logic rd;
      logic idx_clr;
      logic idx_inc;
      logic deg_inc;
      logic emit_inc;
      logic load_col;
      logic load_empty;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic nondom;
      logic cnt_zero;
      logic is_strong;
      logic idx_last;
      logic deg_zero;
      logic emit_last;
      logic out_free;
   } sts_type;

endpackage

// ===== src/amg_scs_dp.sv =====
module amg_scs_dp
   import amg_scs_pkg::*;
#(
   parameter int MAX_ROW_LEN = 32,
   parameter int INDEX_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   input  logic                    csr_valid,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   input  logic [COL_W-1:0]        req_row_index,
   input  logic [COL_W-1:0]        req_col_index,
   input  logic signed [VAL_W-1:0] req_entry_value,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic [COL_W-1:0]        rsp_strong_col,
   output logic                    rsp_col_valid,
   output logic [DEG_W-1:0]        rsp_row_degree,
   output logic                    rsp_last_of_row,
   output logic                    rsp_row_overflow
);

   localparam int CNT_W  = $clog2(MAX_ROW_LEN + 1);
   localparam int ADDR_W = $clog2(MAX_ROW_LEN);
   localparam int CMP_W  = (INDEX_WIDTH < COL_W) ? INDEX_WIDTH : COL_W;
   localparam logic [COL_W-1:0] IDX_MASK = COL_W'((33'd1 << CMP_W) - 33'd1);
   localparam int LHS_W  = SUM_W + 16;

   function automatic logic [MAG_W-1:0] mag_of(input logic [VAL_W-1:0] v);
      logic [VAL_W-1:0] neg;
      begin
         neg = ~v + 1'b1;
         if (!v[VAL_W-1]) begin
            mag_of = v[MAG_W-1:0];
         end else if (neg[VAL_W-1]) begin
            mag_of = '1;
         end else begin
            mag_of = neg[MAG_W-1:0];
         end
      end
   endfunction

   logic [THETA_W-1:0] theta_ff;
   logic [TAU_W-1:0]   tau_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [MAG_W-1:0]   max_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [MAG_W-1:0]   diag_ff;
   logic               ovf_ff;

   logic [COL_W-1:0]   cols_mem [MAX_ROW_LEN];
   logic [MAG_W-1:0]   mags_mem [MAX_ROW_LEN];
   logic [COL_W-1:0]   rd_col_ff;
   logic [MAG_W-1:0]   rd_mag_ff;

   logic [39:0]        prod_lo_ff;
   logic [38:0]        prod_hi_ff;
   logic [47:0]        thr_ff;
   logic               nondom_ff;

   logic [CNT_W-1:0]   idx_ff;
   logic [DEG_W-1:0]   deg_ff;
   logic [DEG_W-1:0]   emit_ff;

   logic               rsp_valid_ff;
   logic [COL_W-1:0]   rsp_col_ff;
   logic               rsp_col_valid_ff;
   logic [DEG_W-1:0]   rsp_deg_ff;
   logic               rsp_last_ff;
   logic               rsp_ovf_ff;

   logic               is_diag;
   logic [COL_W-1:0]   col_in;
   logic [MAG_W-1:0]   mag_in;
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   sum_in;
   logic               has_room;
   logic [LHS_W-1:0]   lhs;
   logic [LHS_W-1:0]   rhs;
   logic [CNT_W-1:0]   idx_next;
   logic [DEG_W-1:0]   emit_next;

   always_comb begin
      col_in    = req_col_index & IDX_MASK;
      is_diag   = (req_row_index & IDX_MASK) == col_in;
      mag_in    = mag_of(req_entry_value);
      sum_wide  = {1'b0, sum_ff} + (SUM_W + 1)'(mag_in);
      sum_in    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      has_room  = count_ff < CNT_W'(MAX_ROW_LEN);
      lhs       = (LHS_W'(prod_hi_ff) << 16) + LHS_W'(prod_lo_ff);
      rhs       = {sum_ff, 16'h0000};
      idx_next  = idx_ff + 1'b1;
      emit_next = emit_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         theta_ff <= THETA_RESET;
         tau_ff   <= TAU_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_THETA) begin
            theta_ff <= csr_data[THETA_W-1:0];
         end else if (csr_index == REG_TAU) begin
            tau_ff <= csr_data[TAU_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
         max_ff   <= '0;
         sum_ff   <= '0;
         diag_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.acc) begin
         if (is_diag) begin
            diag_ff <= mag_in;
         end else begin
            if (mag_in > max_ff) begin
               max_ff <= mag_in;
            end
            sum_ff <= sum_in;
            if (has_room) begin
               count_ff <= count_ff + 1'b1;
            end else begin
               ovf_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc && !is_diag && has_room) begin
         cols_mem[count_ff[ADDR_W-1:0]] <= col_in;
         mags_mem[count_ff[ADDR_W-1:0]] <= mag_in;
      end
      if (cmd.rd) begin
         rd_col_ff <= cols_mem[idx_ff[ADDR_W-1:0]];
         rd_mag_ff <= mags_mem[idx_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_lo) begin
         prod_lo_ff <= 40'(tau_ff) * 40'(diag_ff[15:0]);
         thr_ff     <= 48'(theta_ff) * 48'(max_ff);
      end
      if (cmd.mul_hi) begin
         prod_hi_ff <= 39'(tau_ff) * 39'(diag_ff[MAG_W-1:16]);
      end
      if (cmd.judge) begin
         nondom_ff <= lhs < rhs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.judge) begin
         idx_ff  <= '0;
         deg_ff  <= '0;
         emit_ff <= '0;
      end else begin
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_next;
         end
         if (cmd.deg_inc) begin
            deg_ff <= deg_ff + 1'b1;
         end
         if (cmd.emit_inc) begin
            emit_ff <= emit_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_col || cmd.load_empty) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_col) begin
         rsp_col_ff       <= rd_col_ff;
         rsp_col_valid_ff <= 1'b1;
         rsp_deg_ff       <= deg_ff;
         rsp_last_ff      <= emit_next == deg_ff;
         rsp_ovf_ff       <= ovf_ff;
      end else if (cmd.load_empty) begin
         rsp_col_ff       <= '0;
         rsp_col_valid_ff <= 1'b0;
         rsp_deg_ff       <= '0;
         rsp_last_ff      <= 1'b1;
         rsp_ovf_ff       <= ovf_ff;
      end
   end

   always_comb begin
      sts.nondom    = nondom_ff;
      sts.cnt_zero  = count_ff == '0;
      sts.is_strong = {1'b0, rd_mag_ff, 16'h0000} > thr_ff;
      sts.idx_last  = idx_next == count_ff;
      sts.deg_zero  = deg_ff == '0;
      sts.emit_last = emit_next == deg_ff;
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_strong_col   = rsp_col_ff;
   assign rsp_col_valid    = rsp_col_valid_ff;
   assign rsp_row_degree   = rsp_deg_ff;
   assign rsp_last_of_row  = rsp_last_ff;
   assign rsp_row_overflow = rsp_ovf_ff;

endmodule

// ===== src/amg_scs_ctrl.sv =====
module amg_scs_ctrl
   import amg_scs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_row_end,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_LO,
      S_MUL_HI,
      S_JUDGE,
      S_DECIDE,
      S_CNT_RD,
      S_CNT_CHK,
      S_CNT_END,
      S_EM_RD,
      S_EM_CHK,
      S_EMPTY
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_stall_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.acc = req_valid;
            if (req_valid && req_row_end) begin
               state_in = S_MUL_LO;
            end
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_JUDGE;
         end
         S_JUDGE: begin
            cmd.judge = 1'b1;
            state_in  = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = (sts.nondom && !sts.cnt_zero) ? S_CNT_RD : S_EMPTY;
         end
         S_CNT_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_CNT_CHK;
         end
         S_CNT_CHK: begin
            cmd.deg_inc = sts.is_strong;
            cmd.idx_inc = 1'b1;
            state_in    = sts.idx_last ? S_CNT_END : S_CNT_RD;
         end
         S_CNT_END: begin
            cmd.idx_clr = 1'b1;
            state_in    = sts.deg_zero ? S_EMPTY : S_EM_RD;
         end
         S_EM_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_EM_CHK;
         end
         S_EM_CHK: begin
            if (!sts.is_strong) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_EM_RD;
            end else if (sts.out_free) begin
               cmd.load_col = 1'b1;
               cmd.emit_inc = 1'b1;
               cmd.idx_inc  = 1'b1;
               if (sts.emit_last) begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  state_in = S_EM_RD;
               end
            end
         end
         S_EMPTY: begin
            if (sts.out_free) begin
               cmd.load_empty = 1'b1;
               cmd.clear      = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= state_in != S_IDLE;
      end
   end

   assign req_stall = req_stall_ff;

endmodule

// ===== src/amg_strong_connection_select.sv =====
// Strong-connection selection for one sparse matrix row at a time.
// req_*: one matrix entry per transfer (row, column, Q16.16 value, row-end
//   mark). An entry without the row-end mark is taken without a stall.
// rsp_*: after a row-end transfer the block judges the row and sends the
//   strong columns in arrival order, degree repeated on each, last_of_row on
//   the final one; a diagonally dominant row or an empty selection gives one
//   result with col_valid low. Buffer overflow is flagged on every result.
// csr_*: register writes (index 0 theta, index 1 tau), ready is always high;
//   write only while the block is idle.
// Sequence: entries are buffered as they arrive; after the row end the
//   S_MUL_LO, S_MUL_HI, S_JUDGE and S_DECIDE states form the threshold
//   products (split tau*diag multiply) and the dominance compare, a
//   counting pass finds the degree and an emission pass sends the results;
//   both passes read the buffered entries one at a time. req_stall is high
//   from the row-end transfer until the last result is loaded.
// rsp_stall holds the output register and the emission pass waits on it.
// Reset (synchronous) empties the row state and the output register and
// restores theta to 0.25 and tau to 1.0; the buffer contents are not cleared.
module amg_strong_connection_select
   import amg_scs_pkg::*;
#(
   parameter int MAX_ROW_LEN = 32,
   parameter int INDEX_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [COL_W-1:0]        req_row_index,
   input  logic [COL_W-1:0]        req_col_index,
   input  logic signed [VAL_W-1:0] req_entry_value,
   input  logic                    req_row_end,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [COL_W-1:0]        rsp_strong_col,
   output logic                    rsp_col_valid,
   output logic [DEG_W-1:0]        rsp_row_degree,
   output logic                    rsp_last_of_row,
   output logic                    rsp_row_overflow,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   amg_scs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_row_end (req_row_end),
      .req_stall   (req_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   amg_scs_dp #(
      .MAX_ROW_LEN (MAX_ROW_LEN),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_entry_value  (req_entry_value),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_strong_col   (rsp_strong_col),
      .rsp_col_valid    (rsp_col_valid),
      .rsp_row_degree   (rsp_row_degree),
      .rsp_last_of_row  (rsp_last_of_row),
      .rsp_row_overflow (rsp_row_overflow)
   );

endmodule

// ===== src/amg_scs_checker.sv =====
`include "amg_strong_connection_select_macros.svh"

module amg_scs_checker
   import amg_scs_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    req_row_end,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [COL_W-1:0]        rsp_strong_col,
   input logic                    rsp_col_valid,
   input logic [DEG_W-1:0]        rsp_row_degree,
   input logic                    rsp_last_of_row
);

   `AMG_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_strong_col) && $stable(rsp_row_degree) && $stable(rsp_last_of_row), "stalled result changed")
   `AMG_ASSERT_IMP(a_empty_last, clock, reset, rsp_valid && !rsp_col_valid, rsp_last_of_row && rsp_row_degree == 7'd0, "empty result not final or nonzero degree")
   `AMG_ASSERT_IMP(a_col_degree, clock, reset, rsp_valid && rsp_col_valid, rsp_row_degree != 7'd0, "column result with zero degree")
   `AMG_ASSERT_NXT(a_row_end_busy, clock, reset, req_valid && !req_stall && req_row_end, req_stall, "input taken right after row end")

endmodule

bind amg_strong_connection_select amg_scs_checker u_amg_scs_checker (.*);

// ===== verif/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import amg_scs_pkg::*;

   localparam int ROW_BUF = 32;
   localparam longint CYCLE_LIMIT = 500000;
   localparam int PHASES = 7;
   localparam int DRILL_LEN = 31;
   localparam logic [CSR_IDX_W-1:0] REG_NONE = '1;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             cvalid;
      logic [DEG_W-1:0] deg;
      logic             last;
      logic             ovf;
   } link_type;

   typedef enum logic {STEP_ENTRY, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type         kind;
      logic [COL_W-1:0]      row;
      logic [COL_W-1:0]      col;
      logic [VAL_W-1:0]      val;
      logic                  fin;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic                  typed;
      link_type              want;
   } drill_step_type;

   localparam link_type EMPTY_LINK = '{16'h0, 1'b0, 7'd0, 1'b1, 1'b0};

   // typed expectations only where the outcome is obvious
   localparam drill_step_type DRILL [DRILL_LEN] = '{
      '{STEP_ENTRY, 16'h0000, 16'h0000, 32'h0001_0000, 1'b1, REG_THETA, 24'h0, 1'b1, EMPTY_LINK},
      '{STEP_ENTRY, 16'h0007, 16'h0003, 32'h0000_0005, 1'b1, REG_THETA, 24'h0, 1'b1,
        '{16'h0003, 1'b1, 7'd1, 1'b1, 1'b0}},
      '{STEP_ENTRY, 16'hFFFF, 16'h0000, 32'h8000_0000, 1'b0, REG_THETA, 24'h0, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 1'b0, REG_THETA, 24'h0, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'hFFFF, 16'h0001, 32'h7FFF_FFFF, 1'b1, REG_THETA, 24'h0, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'h0005, 16'h0005, 32'h0000_03E8, 1'b0, REG_THETA, 24'h0, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'h0005, 16'h0009, 32'h0000_000A, 1'b0, REG_THETA, 24'h0, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'h0005, 16'h0005, 32'hFFFF_FFFD, 1'b1, REG_THETA, 24'h0, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'h0002, 16'h0002, 32'h0000_0064, 1'b0, REG_THETA, 24'h0, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'h0002, 16'h0001, 32'h0000_0032, 1'b0, REG_THETA, 24'h0, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'h0002, 16'h0003, 32'hFFFF_FFCE, 1'b1, REG_THETA, 24'h0, 1'b1, EMPTY_LINK},
      '{STEP_ENTRY, 16'h0004, 16'h0000, 32'hFFFF_FC18, 1'b0, REG_THETA, 24'h0, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'h0004, 16'h0001, 32'h0000_0064, 1'b0, REG_THETA, 24'h0, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'h0004, 16'h0002, 32'h0000_00FA, 1'b0, REG_THETA, 24'h0, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'h0004, 16'h0003, 32'h0000_00FB, 1'b1, REG_THETA, 24'h0, 1'b0, EMPTY_LINK},
      '{STEP_CSR, 16'h0, 16'h0, 32'h0, 1'b0, REG_THETA, 24'h01_0000, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'h0008, 16'h0001, 32'h0000_0007, 1'b0, REG_THETA, 24'h0, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'h0008, 16'h0002, 32'hFFFF_FFF9, 1'b1, REG_THETA, 24'h0, 1'b1, EMPTY_LINK},
      '{STEP_CSR, 16'h0, 16'h0, 32'h0, 1'b0, REG_THETA, 24'h00_0000, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'h0009, 16'h0004, 32'h0000_0000, 1'b0, REG_THETA, 24'h0, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'h0009, 16'h0006, 32'h0000_0001, 1'b1, REG_THETA, 24'h0, 1'b0, EMPTY_LINK},
      '{STEP_CSR, 16'h0, 16'h0, 32'h0, 1'b0, REG_TAU, 24'hFF_FFFF, 1'b0, EMPTY_LINK},
      '{STEP_CSR, 16'h0, 16'h0, 32'h0, 1'b0, REG_THETA, 24'hFF_FFFF, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'h0003, 16'h0003, 32'h0000_0001, 1'b0, REG_THETA, 24'h0, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'h0003, 16'h0000, 32'h7FFF_FFFF, 1'b1, REG_THETA, 24'h0, 1'b1, EMPTY_LINK},
      '{STEP_CSR, 16'h0, 16'h0, 32'h0, 1'b0, REG_TAU, 24'h00_0000, 1'b0, EMPTY_LINK},
      '{STEP_CSR, 16'h0, 16'h0, 32'h0, 1'b0, REG_THETA, 24'h00_4000, 1'b0, EMPTY_LINK},
      '{STEP_CSR, 16'h0, 16'h0, 32'h0, 1'b0, REG_NONE, 24'hFF_FFFF, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'h000A, 16'h000A, 32'h7FFF_FFFF, 1'b0, REG_THETA, 24'h0, 1'b0, EMPTY_LINK},
      '{STEP_ENTRY, 16'h000A, 16'h000B, 32'h0000_0001, 1'b1, REG_THETA, 24'h0, 1'b1,
        '{16'h000B, 1'b1, 7'd1, 1'b1, 1'b0}},
      '{STEP_CSR, 16'h0, 16'h0, 32'h0, 1'b0, REG_TAU, 24'h01_0000, 1'b0, EMPTY_LINK}
   };

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [COL_W-1:0]        req_row_index;
   logic [COL_W-1:0]        req_col_index;
   logic signed [VAL_W-1:0] req_entry_value;
   logic                    req_row_end;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [COL_W-1:0]        rsp_strong_col;
   logic                    rsp_col_valid;
   logic [DEG_W-1:0]        rsp_row_degree;
   logic                    rsp_last_of_row;
   logic                    rsp_row_overflow;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   amg_strong_connection_select dut (.*);

   // row model state
   logic [COL_W-1:0]   buf_cols [ROW_BUF];
   logic [MAG_W-1:0]   buf_mags [ROW_BUF];
   int                 buf_count = 0;
   logic [MAG_W-1:0]   peak_mag = '0;
   logic [SUM_W-1:0]   mag_sum = '0;
   logic [MAG_W-1:0]   pivot_mag = '0;
   logic               buf_full_seen = 1'b0;
   logic [THETA_W-1:0] theta_q = THETA_RESET;
   logic [TAU_W-1:0]   tau_q = TAU_RESET;

   link_type fresh_links [$];
   link_type expected_links [$];
   bit     bursty = 1'b1;
   int     errors = 0;
   int     entries_sent = 0;
   int     rows_judged = 0;
   int     rows_overflowed = 0;
   int     links_checked = 0;
   int     csr_writes = 0;
   longint cycle_count = 0;
   int     stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [MAG_W-1:0] mag_of(logic [VAL_W-1:0] v);
      logic [VAL_W-1:0] m;
      m = v[VAL_W-1] ? (~v + 32'd1) : v;
      if (m > 32'h7FFF_FFFF) m = 32'h7FFF_FFFF;
      return m[MAG_W-1:0];
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      logic [VAL_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = $urandom;
         3, 4, 5: v = $urandom_range(0, 2000);
         6, 7:    v = $urandom_range(0, 1 << 20);
         8:       v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: v = $urandom_range(0, 1);
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   // fold one entry into the row state; on row end fill fresh_links
   task automatic absorb_entry(input logic [COL_W-1:0] r, input logic [COL_W-1:0] c,
                               input logic [VAL_W-1:0] v, input logic fin);
      logic [MAG_W-1:0] m;
      logic [SUM_W:0]   wide;
      logic [63:0]      lhs, rhs, thr;
      int               n;
      m = mag_of(v);
      fresh_links.delete();
      if (c == r) begin
         pivot_mag = m;
      end else begin
         if (m > peak_mag) peak_mag = m;
         wide = {1'b0, mag_sum} + 41'(m);
         mag_sum = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
         if (buf_count < ROW_BUF) begin
            buf_cols[buf_count] = c;
            buf_mags[buf_count] = m;
            buf_count++;
         end else begin
            buf_full_seen = 1'b1;
         end
      end
      if (!fin) return;
      lhs = 64'(tau_q) * 64'(pivot_mag);
      rhs = 64'(mag_sum) << 16;
      thr = 64'(theta_q) * 64'(peak_mag);
      if (lhs < rhs) begin
         for (int k = 0; k < buf_count; k++) begin
            if ((64'(buf_mags[k]) << 16) > thr)
               fresh_links.push_back('{buf_cols[k], 1'b1, 7'd0, 1'b0, 1'b0});
         end
      end
      n = fresh_links.size();
      if (n == 0) begin
         fresh_links.push_back('{16'h0, 1'b0, 7'd0, 1'b1, buf_full_seen});
      end else begin
         for (int k = 0; k < n; k++) begin
            fresh_links[k].deg = DEG_W'(n);
            fresh_links[k].last = (k == n - 1);
            fresh_links[k].ovf = buf_full_seen;
         end
      end
      rows_judged++;
      if (buf_full_seen) rows_overflowed++;
      buf_count = 0;
      peak_mag = '0;
      mag_sum = '0;
      pivot_mag = '0;
      buf_full_seen = 1'b0;
   endtask

   task automatic send_entry(input logic [COL_W-1:0] r, input logic [COL_W-1:0] c,
                             input logic [VAL_W-1:0] v, input logic fin,
                             input logic typed, input link_type want);
      if (bursty && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_row_index <= r;
      req_col_index <= c;
      req_entry_value <= v;
      req_row_end <= fin;
      do @(posedge clock); while (req_stall);
      absorb_entry(r, c, v, fin);
      if (typed && fin) expected_links.push_back(want);
      else foreach (fresh_links[k]) expected_links.push_back(fresh_links[k]);
      entries_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_links.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_THETA) theta_q = d[THETA_W-1:0];
      else if (idx == REG_TAU) tau_q = d;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_row(input int len, input bit noise);
      logic [COL_W-1:0] r, c;
      logic             fin;
      r = $urandom;
      for (int k = 0; k < len; k++) begin
         if (noise) r = $urandom;
         c = ($urandom_range(0, 4) == 0) ? r : COL_W'($urandom);
         fin = (k == len - 1) || (noise && $urandom_range(0, 3) == 0);
         send_entry(r, c, pick_value(), fin, 1'b0, EMPTY_LINK);
      end
   endtask

   function automatic void compare_field(string name, logic [COL_W-1:0] want,
                                         logic [COL_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (bursty && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      link_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_links.size() == 0) begin
            errors++;
            $display("%0t: rsp transfer expected none, got col %0h valid %0b deg %0d",
                     $time, rsp_strong_col, rsp_col_valid, rsp_row_degree);
         end else begin
            want = expected_links.pop_front();
            compare_field("strong_col", want.col, rsp_strong_col);
            compare_field("col_valid", 16'(want.cvalid), 16'(rsp_col_valid));
            compare_field("row_degree", 16'(want.deg), 16'(rsp_row_degree));
            compare_field("last_of_row", 16'(want.last), 16'(rsp_last_of_row));
            compare_field("row_overflow", 16'(want.ovf), 16'(rsp_row_overflow));
            links_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_links.size());
         $display("amg_strong_connection_select test failed");
         $finish;
      end
   end

   initial begin
      int                    target;
      int                    len;
      bit                    held;
      bit                    tau_first;
      logic [THETA_W-1:0]    theta_w;
      logic [TAU_W-1:0]      tau_w;
      held = 1'b0;
      reset = 1'b1;
      rsp_stall = 1'b0;
      req_valid = 1'b0;
      req_row_index = '0;
      req_col_index = '0;
      req_entry_value = '0;
      req_row_end = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DRILL_LEN; i++) begin
         if (DRILL[i].kind == STEP_CSR) begin
            drain();
            csr_write(DRILL[i].idx, DRILL[i].data);
         end else begin
            send_entry(DRILL[i].row, DRILL[i].col, DRILL[i].val, DRILL[i].fin,
                       DRILL[i].typed, DRILL[i].want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         drain();
         bursty = (p != PHASES - 1);
         case ($urandom_range(0, 5))
            0:       theta_w = '0;
            1:       theta_w = 17'd16384;
            2:       theta_w = 17'd65536;
            3:       theta_w = '1;
            default: theta_w = $urandom_range(1, 65535);
         endcase
         case ($urandom_range(0, 5))
            0:       tau_w = '0;
            1:       tau_w = 24'd65536;
            2:       tau_w = '1;
            3:       tau_w = $urandom;
            default: tau_w = $urandom_range(16384, 262144);
         endcase
         tau_first = $urandom_range(0, 1);
         for (int w = 0; w < 2; w++) begin
            if ((w == 0) == tau_first) csr_write(REG_TAU, tau_w);
            else csr_write(REG_THETA, {7'($urandom), theta_w});
         end
         if ($urandom_range(0, 2) == 0)
            csr_write(CSR_IDX_W'($urandom_range(int'(REG_NONE), int'(REG_TAU) + 1)),
                      CSR_DATA_W'($urandom));
         target = entries_sent + 57;
         while (entries_sent < target) begin
            if (p == PHASES / 2 && !held && entries_sent >= target - 30) begin
               drain();
               held = 1'b1;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
            send_row(len, $urandom_range(0, 6) == 0);
         end
      end

      drain();
      repeat (20) @(negedge clock);
      $display("Sent %0d entries over %0d judged rows (%0d past the buffer), %0d CSR writes.",
               entries_sent, rows_judged, rows_overflowed, csr_writes);
      $display("Checked %0d results with %0d field mismatches.", links_checked, errors);
      if (errors == 0) begin
         $display("amg_strong_connection_select test passed");
      end else begin
         $display("amg_strong_connection_select test failed");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+src
src/amg_scs_pkg.sv
src/amg_scs_dp.sv
src/amg_scs_ctrl.sv
src/amg_strong_connection_select.sv
src/amg_scs_checker.sv
verif/tb.sv
